>>> design/chcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcr_pkg
// Shared types and constants for the hex colour rewriter: the output segment
// codes, the controller/datapath command and status groups and the literals.
// ----------------------------------------------------------------------------
package chcr_pkg;

    localparam int CHAR_W  = 16;
    localparam int DIGIT_W = 7;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 4;

    localparam logic [CHAR_W-1:0]  CHAR_HASH = 16'h0023;
    localparam logic [DIGIT_W-1:0] CHAR_ZERO = 7'h30;

    localparam logic [IDX_W-1:0] WORD_LEN  = 4'd11;
    localparam logic [IDX_W-1:0] SHORT_LEN = 4'd4;
    localparam logic [CNT_W-1:0] CNT_SHORT = 4'd4;
    localparam logic [CNT_W-1:0] CNT_LONG  = 4'd8;

    // where the unit being sent comes from
    typedef enum logic [1:0] {
        SEG_RUN  = 2'd0,
        SEG_CHAR = 2'd1,
        SEG_HASH = 2'd2,
        SEG_MARK = 2'd3
    } seg_t;

    typedef struct packed {
        logic             accept;
        logic             load;
        seg_t             seg;
        logic [IDX_W-1:0] idx;
        logic             fin;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic             has_run;
        logic             has_char;
        logic             has_hash;
        logic             last;
        logic [IDX_W-1:0] run_len;
        logic             slot_free;
    } stat_t;

    // the replacement word, one letter per position
    function automatic logic [DIGIT_W-1:0] word_char(input logic [IDX_W-1:0] i);
        logic [DIGIT_W-1:0] c;
        case (i)
            4'd0:    c = 7'h74; // t
            4'd1:    c = 7'h72; // r
            4'd2:    c = 7'h61; // a
            4'd3:    c = 7'h6E; // n
            4'd4:    c = 7'h73; // s
            4'd5:    c = 7'h70; // p
            4'd6:    c = 7'h61; // a
            4'd7:    c = 7'h72; // r
            4'd8:    c = 7'h65; // e
            4'd9:    c = 7'h6E; // n
            default: c = 7'h74; // t
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/chcr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcr_ctrl
// Sequencer: takes one code unit, then walks the planned output segments
// (held run, the unit itself, a trailing hash, or the empty end marker).
// ----------------------------------------------------------------------------
module chcr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire chcr_pkg::stat_t stat,
    output chcr_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PLAN = 6'b000010,
        ST_RUN  = 6'b000100,
        ST_CHAR = 6'b001000,
        ST_HASH = 6'b010000,
        ST_MARK = 6'b100000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [chcr_pkg::IDX_W-1:0] idx_reg;
    logic [chcr_pkg::IDX_W-1:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.seg    = chcr_pkg::SEG_RUN;
        cmd.idx    = idx_reg;
        cmd.fin    = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                idx_next = '0;
                if (stat.has_run)
                    state_next = ST_RUN;
                else if (stat.has_char)
                    state_next = ST_CHAR;
                else if (stat.has_hash)
                    state_next = ST_HASH;
                else if (stat.last)
                    state_next = ST_MARK;
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                cmd.seg = chcr_pkg::SEG_RUN;
                if (stat.slot_free)
                begin
                    cmd.load = 1'b1;
                    if (idx_reg == stat.run_len - 4'd1)
                    begin
                        idx_next = '0;
                        cmd.fin  = !stat.has_char && !stat.has_hash;
                        if (stat.has_char)
                            state_next = ST_CHAR;
                        else if (stat.has_hash)
                            state_next = ST_HASH;
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                        idx_next = idx_reg + 4'd1;
                end
            end
            ST_CHAR:
            begin
                cmd.seg = chcr_pkg::SEG_CHAR;
                if (stat.slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.fin  = !stat.has_hash;
                    if (stat.has_hash)
                        state_next = ST_HASH;
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HASH:
            begin
                cmd.seg = chcr_pkg::SEG_HASH;
                if (stat.slot_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.fin    = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                cmd.seg = chcr_pkg::SEG_MARK;
                if (stat.slot_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.fin    = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/chcr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcr_datapath
// Digit store, run state, per-unit plan flags, output unit selection and the
// output register that decouples the result side.
// ----------------------------------------------------------------------------
module chcr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          strip_surrogates,
    input  wire logic [chcr_pkg::CHAR_W-1:0]   in_char,
    input  wire logic                          in_last,
    input  wire chcr_pkg::cmd_t                cmd,
    output chcr_pkg::stat_t                    stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [chcr_pkg::CHAR_W-1:0]        out_char,
    output logic                               char_valid,
    output logic                               run_end,
    output logic                               text_end
);

    logic [chcr_pkg::DIGIT_W-1:0] digit_store [8];

    logic                         collecting_reg;
    logic [chcr_pkg::CNT_W-1:0]   hex_count_reg;
    logic [chcr_pkg::CHAR_W-1:0]  char_reg;
    logic                         has_run_reg;
    logic                         has_char_reg;
    logic                         has_hash_reg;
    logic                         last_reg;
    logic                         force_full_reg;
    logic                         coll_fin_reg;
    logic                         keep_count_reg;

    logic                         out_valid_reg;
    logic [chcr_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         char_valid_reg;
    logic                         run_end_reg;
    logic                         text_end_reg;

    logic                         in_hex;
    logic                         in_hash;
    logic                         in_sur;
    logic                         store;
    logic                         flush;
    logic                         use_word;
    logic                         use_short;
    logic [chcr_pkg::IDX_W-1:0]   idx_m1;
    logic [chcr_pkg::CHAR_W-1:0]  unit;

    assign in_hex = (in_char >= 16'h0030 && in_char <= 16'h0039)
                 || (in_char >= 16'h0041 && in_char <= 16'h0046)
                 || (in_char >= 16'h0061 && in_char <= 16'h0066);
    assign in_hash = (in_char == chcr_pkg::CHAR_HASH);
    assign in_sur  = (in_char[15:11] == 5'b11011);
    assign store   = collecting_reg && in_hex && !hex_count_reg[3];
    assign flush   = collecting_reg && in_hex && hex_count_reg[3];

    always_ff @(posedge clk)
    begin
        if (cmd.accept && store)
            digit_store[hex_count_reg[2:0]] <= in_char[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            hex_count_reg  <= '0;
            has_run_reg    <= 1'b0;
            has_char_reg   <= 1'b0;
            has_hash_reg   <= 1'b0;
            last_reg       <= 1'b0;
            force_full_reg <= 1'b0;
            coll_fin_reg   <= 1'b0;
            keep_count_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            last_reg <= in_last;
            if (store)
            begin
                hex_count_reg  <= hex_count_reg + 4'd1;
                has_run_reg    <= in_last;
                has_char_reg   <= 1'b0;
                has_hash_reg   <= 1'b0;
                force_full_reg <= 1'b0;
                coll_fin_reg   <= !in_last;
                keep_count_reg <= !in_last;
            end
            else if (flush)
            begin
                has_run_reg    <= 1'b1;
                has_char_reg   <= 1'b1;
                has_hash_reg   <= 1'b0;
                force_full_reg <= 1'b1;
                coll_fin_reg   <= 1'b0;
                keep_count_reg <= 1'b0;
            end
            else
            begin
                has_run_reg    <= collecting_reg;
                has_char_reg   <= !in_hash && !(strip_surrogates && in_sur);
                has_hash_reg   <= in_hash && in_last;
                force_full_reg <= 1'b0;
                coll_fin_reg   <= in_hash && !in_last;
                keep_count_reg <= 1'b0;
            end
        end
        else if (cmd.finish)
        begin
            collecting_reg <= coll_fin_reg;
            if (!keep_count_reg)
                hex_count_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            char_reg <= in_char;
    end

    // run resolution from the held digits
    assign use_word = !force_full_reg
        && ((hex_count_reg == chcr_pkg::CNT_SHORT && digit_store[3] == chcr_pkg::CHAR_ZERO)
         || (hex_count_reg == chcr_pkg::CNT_LONG && digit_store[6] == chcr_pkg::CHAR_ZERO
             && digit_store[7] == chcr_pkg::CHAR_ZERO));
    assign use_short = !force_full_reg && !use_word
                    && (hex_count_reg == chcr_pkg::CNT_SHORT);
    assign idx_m1 = cmd.idx - 4'd1;

    always_comb
    begin
        unit = '0;
        case (cmd.seg)
            chcr_pkg::SEG_RUN:
            begin
                if (use_word)
                    unit = {9'd0, chcr_pkg::word_char(cmd.idx)};
                else if (cmd.idx == '0)
                    unit = chcr_pkg::CHAR_HASH;
                else
                    unit = {9'd0, digit_store[idx_m1[2:0]]};
            end
            chcr_pkg::SEG_CHAR: unit = char_reg;
            chcr_pkg::SEG_HASH: unit = chcr_pkg::CHAR_HASH;
            chcr_pkg::SEG_MARK: unit = '0;
        endcase
    end

    always_comb
    begin
        stat.has_run   = has_run_reg;
        stat.has_char  = has_char_reg;
        stat.has_hash  = has_hash_reg;
        stat.last      = last_reg;
        stat.slot_free = !out_valid_reg || out_ready;
        if (use_word)
            stat.run_len = chcr_pkg::WORD_LEN;
        else if (use_short)
            stat.run_len = chcr_pkg::SHORT_LEN;
        else
            stat.run_len = hex_count_reg + 4'd1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_char_reg   <= unit;
            char_valid_reg <= (cmd.seg != chcr_pkg::SEG_MARK);
            run_end_reg    <= cmd.fin;
            text_end_reg   <= cmd.fin && last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign run_end    = run_end_reg;
    assign text_end   = text_end_reg;

endmodule
`default_nettype wire

>>> design/css_hex_color_rewriter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// css_hex_color_rewriter
// Streaming rewriter of CSS hex colours in UTF-16 text, with an APB-style
// register for surrogate stripping.
// ----------------------------------------------------------------------------
// One code unit is taken at a time. Each unit is taken, then planned, then
// sends each result unit it produces (up to twelve); a unit that releases a
// colour run sends the run and then any closing unit or hash after it. The
// output register sends one unit per cycle and the sequencer waits on it while
// the sink stalls. A new unit is taken once the previous one has handed its
// last result to the output register, while that result may still be waiting.
// tlast marks the last result of the text; a final unit with nothing to send
// yields one result with the character flag low.
module css_hex_color_rewriter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] in_char
    input  wire logic        s_axis_tlast,  // in_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [15:0] out_char
    output logic [1:0]       m_axis_tuser,  // [0] char_valid, [1] run_end
    output logic             m_axis_tlast,  // text_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    chcr_pkg::cmd_t  cmd;
    chcr_pkg::stat_t stat;
    logic            strip_reg;
    logic            char_valid;
    logic            run_end;

    // register 0 at byte address 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strip_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && !paddr[2])
            strip_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, strip_reg};

    chcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chcr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .strip_surrogates (strip_reg),
        .in_char          (s_axis_tdata),
        .in_last          (s_axis_tlast),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_char         (m_axis_tdata),
        .char_valid       (char_valid),
        .run_end          (run_end),
        .text_end         (m_axis_tlast)
    );

    assign m_axis_tuser = {run_end, char_valid};

endmodule
`default_nettype wire

>>> bench/css_hex_color_rewriter_tb.sv
// ----------------------------------------------------------------------------
// css_hex_color_rewriter_tb
// Drives UTF-16 text through the colour rewriter, most of it well-formed hex
// colour runs with random content, and compares every output transfer with a
// predictor of the rewrite. Both stream sides idle at random, and the strip
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module css_hex_color_rewriter_tb;

    localparam int LIMIT = 500000;

    localparam logic [2:0] ADDR_STRIP = 3'd0;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    localparam logic [15:0] CH_HASH    = 16'h0023;
    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_UPPER_A = 16'h0041;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [87:0] WORD       = "transparent";

    typedef struct packed {
        logic [15:0] code_unit;
        logic        char_valid;
        logic        run_end;
        logic        text_end;
    } unit_out_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
        logic        typed;
        unit_out_t   want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    wire         m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    // predictor state
    logic        m_strip = 1'b1;
    logic        m_collect = 1'b0;
    logic [3:0]  m_count = '0;
    logic [6:0]  m_digits [8];
    logic [15:0] step_units [$];
    unit_out_t   step_out [$];

    unit_out_t   expected_out [$];
    plan_row_t   plan [$];

    logic        calm = 1'b0;
    int          stall_left = 0;
    int          cycles = 0;
    int          errors = 0;
    int          n_units = 0;
    int          n_results = 0;
    int          n_writes = 0;

    css_hex_color_rewriter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic is_hex_digit(input logic [15:0] c);
        return (c >= 16'h0030 && c <= 16'h0039) || (c >= 16'h0041 && c <= 16'h0046) ||
               (c >= 16'h0061 && c <= 16'h0066);
    endfunction

    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return CH_ZERO + 16'(r);
        if (r < 16)
            return CH_LOWER_A + 16'(r - 10);
        return CH_UPPER_A + 16'(r - 16);
    endfunction

    function automatic logic [15:0] rand_other();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0020, 16'h007E));
            1: return 16'($urandom_range(SURR_LO, SURR_HI));
            2: return 16'($urandom());
            default: return CH_HASH;
        endcase
    endfunction

    function automatic plan_row_t row(input logic [15:0] c, input logic l, input logic t,
                                      input unit_out_t w);
        return {c, l, t, w};
    endfunction

    task automatic emit_held();
        step_units.push_back(CH_HASH);
        for (int i = 0; i < m_count; i++)
            step_units.push_back({9'd0, m_digits[i]});
    endtask

    task automatic emit_word();
        for (int i = 0; i < 11; i++)
            step_units.push_back({8'd0, WORD[8*(10-i) +: 8]});
    endtask

    // a held colour run ends on a non-hex unit or at the end of text
    task automatic settle_run();
        if (!m_collect)
            return;
        if (m_count == 4'd4)
        begin
            if (m_digits[3] == CH_ZERO[6:0])
                emit_word();
            else
            begin
                step_units.push_back(CH_HASH);
                for (int i = 0; i < 3; i++)
                    step_units.push_back({9'd0, m_digits[i]});
            end
        end
        else if (m_count == 4'd8 && m_digits[6] == CH_ZERO[6:0] &&
                 m_digits[7] == CH_ZERO[6:0])
            emit_word();
        else
            emit_held();
        m_collect = 1'b0;
        m_count = '0;
    endtask

    task automatic rewrite_unit(input logic [15:0] c, input logic l);
        int n;
        step_units.delete();
        step_out.delete();
        if (m_collect && is_hex_digit(c))
        begin
            if (m_count < 4'd8)
            begin
                m_digits[m_count[2:0]] = c[6:0];
                m_count = m_count + 4'd1;
            end
            else
            begin
                emit_held();
                step_units.push_back(c);
                m_collect = 1'b0;
                m_count = '0;
            end
        end
        else
        begin
            settle_run();
            if (c == CH_HASH)
            begin
                m_collect = 1'b1;
                m_count = '0;
            end
            else if (!(m_strip && c >= SURR_LO && c <= SURR_HI))
                step_units.push_back(c);
        end
        if (l)
            settle_run();
        n = step_units.size();
        if (n == 0 && l)
            step_out.push_back({16'h0000, 1'b0, 1'b1, 1'b1});
        for (int k = 0; k < n; k++)
            step_out.push_back({step_units[k], 1'b1, k == n - 1, (k == n - 1) && l});
    endtask

    task automatic feed_unit(input logic [15:0] c, input logic l, input logic typed,
                             input unit_out_t want);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 2) == 0)
            gap = pause_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        rewrite_unit(c, l);
        n_units++;
        if (typed)
            expected_out.push_back(want);
        else
            foreach (step_out[k])
                expected_out.push_back(step_out[k]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_for_write();
        drain_results();
        repeat (16) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_STRIP)
            m_strip = data[0];
        n_writes++;
    endtask

    // mostly well-formed colour runs, the rest loose units
    task automatic random_text(input int count);
        int start;
        int n;
        logic l;
        logic [15:0] c;
        start = n_units;
        while (n_units - start < count)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                feed_unit(CH_HASH, 1'b0, 1'b0, '0);
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(0, 10);
                    1, 2:    n = 4;
                    3, 4:    n = 8;
                    5:       n = 9;
                    6:       n = 3;
                    default: n = $urandom_range(1, 9);
                endcase
                l = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    c = rand_hex();
                    if (n == 4 && i == 3 && $urandom_range(0, 1) == 1)
                        c = CH_ZERO;
                    if (n == 8 && i >= 6 && $urandom_range(0, 2) != 0)
                        c = CH_ZERO;
                    l = (i == n - 1) && ($urandom_range(0, 7) == 0);
                    feed_unit(c, l, 1'b0, '0);
                end
                if (!l)
                    feed_unit(rand_other(), $urandom_range(0, 5) == 0, 1'b0, '0);
            end
            else
                feed_unit(rand_other(), $urandom_range(0, 9) == 0, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= pause_len();
        end
    end

    always @(posedge clk)
    begin
        unit_out_t got;
        unit_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
            n_results++;
            if (expected_out.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: unit %h valid %b run_end %b text_end %b",
                             got.code_unit, got.char_valid, got.run_end, got.text_end);
            end
            else
            begin
                want = expected_out.pop_front();
                if (got.code_unit !== want.code_unit || got.char_valid !== want.char_valid ||
                    got.run_end !== want.run_end || got.text_end !== want.text_end)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.code_unit, want.char_valid, want.run_end,
                                 want.text_end, got.code_unit, got.char_valid,
                                 got.run_end, got.text_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("css_hex_color_rewriter_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain units, extremes and a stripped surrogate that ends the text
        plan.push_back(row(16'h0041, 1'b0, 1'b1, {16'h0041, 3'b110}));
        plan.push_back(row(16'h0000, 1'b0, 1'b1, {16'h0000, 3'b110}));
        plan.push_back(row(16'hFFFF, 1'b0, 1'b1, {16'hFFFF, 3'b110}));
        plan.push_back(row(SURR_HI, 1'b1, 1'b1, {16'h0000, 3'b011}));
        // four digits ending in zero, closed by a second hash
        plan.push_back(row(CH_HASH, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0061, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0042, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0063, 1'b0, 1'b0, '0));
        plan.push_back(row(CH_ZERO, 1'b0, 1'b0, '0));
        plan.push_back(row(CH_HASH, 1'b0, 1'b0, '0));
        // short form kept, then a lone hash at end of text
        plan.push_back(row(16'h0046, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0066, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0039, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0031, 1'b0, 1'b0, '0));
        plan.push_back(row(CH_HASH, 1'b1, 1'b0, '0));
        // eight digits ending in 00, closed by a dropped surrogate at end
        plan.push_back(row(CH_HASH, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0031, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0032, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0033, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0044, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0065, 1'b0, 1'b0, '0));
        plan.push_back(row(16'h0066, 1'b0, 1'b0, '0));
        plan.push_back(row(CH_ZERO, 1'b0, 1'b0, '0));
        plan.push_back(row(CH_ZERO, 1'b0, 1'b0, '0));
        plan.push_back(row(16'hD83D, 1'b1, 1'b0, '0));
        foreach (plan[i])
            feed_unit(plan[i].code_unit, plan[i].last, plan[i].typed, plan[i].want);

        // unused address must leave stripping on
        settle_for_write();
        apb_write(ADDR_SPARE, 32'h0000_0000);
        random_text(40);

        settle_for_write();
        apb_write(ADDR_STRIP, 32'h0000_0000);
        calm = 1'b1;
        random_text(25);
        calm = 1'b0;
        drain_results();
        random_text(25);

        settle_for_write();
        apb_write(ADDR_STRIP, 32'hFFFF_FFFF);
        random_text(45);

        settle_for_write();
        apb_write(ADDR_STRIP, 32'h0000_0000);
        random_text(45);

        drain_results();
        repeat (20) @(posedge clk);
        $display("css_hex_color_rewriter_tb: %0d code units in, %0d transfers checked",
                 n_units, n_results);
        $display("css_hex_color_rewriter_tb: %0d register writes, stripping on and off",
                 n_writes);
        if (errors == 0 && expected_out.size() == 0)
            $display("css_hex_color_rewriter_tb: done, clean");
        else
            $display("css_hex_color_rewriter_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/chcr_pkg.sv
design/chcr_ctrl.sv
design/chcr_datapath.sv
design/css_hex_color_rewriter.sv
bench/css_hex_color_rewriter_tb.sv
